// ===== design/dfrq_pkg.sv =====
// shared types, constants and control/status bundles for the forest root query unit
package dfrq_pkg;

   localparam int unsigned IDX_W          = 16;
   localparam int unsigned SLOT_MAX       = 65536;
   localparam int unsigned NODE_COUNT_DEF = 65536;

   typedef logic [IDX_W-1:0] idx_type;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_MOVE  = 2'd1,
      OP_QUERY = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_STEP,
      ST_FETCH,
      ST_FINISH,
      ST_COMMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clear_step;
      logic capture;
      logic start_np;
      logic fetch;
      logic advance;
      logic reply;
      logic commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic writable;
      logic np_zero;
      logic step_full;
      logic pos_hit;
      logic pos_in_store;
      logic parent_zero;
      logic out_free;
   } sts_type;

endpackage

// ===== design/dfrq_req_if.sv =====
// request channel: op, node and new parent with valid/ready
interface dfrq_req_if;
   import dfrq_pkg::*;

   logic       valid;
   logic       ready;
   logic [1:0] op;
   idx_type    node;
   idx_type    new_parent;

   modport source (output valid, output op, output node, output new_parent, input ready);
   modport sink   (input valid, input op, input node, input new_parent, output ready);
endinterface

// ===== design/dfrq_rsp_if.sv =====
// response channel: root index with valid/ready
interface dfrq_rsp_if;
   import dfrq_pkg::*;

   logic    valid;
   logic    ready;
   idx_type root;

   modport source (output valid, output root, input ready);
   modport sink   (input valid, input root, output ready);
endinterface

// ===== design/dfrq_ctrl.sv =====
// controller state machine: clearing pass, request decode and parent chain walk sequencing
module dfrq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [1:0]        req_op,
   input  dfrq_pkg::sts_type sts,
   output logic              req_ready,
   output dfrq_pkg::cmd_type cmd
);
   import dfrq_pkg::*;

   state_type state_ff;
   state_type state_in;
   op_type    op_ff;
   op_type    op_in;
   logic      is_move;
   logic      walk_stop;

   assign is_move   = (op_ff == OP_MOVE);
   // step limit, reached the moved node, or a zero / out-of-store index
   assign walk_stop = sts.step_full || (is_move && sts.pos_hit) || !sts.pos_in_store;

   assign op_in = (state_ff == ST_IDLE && req_valid) ? op_type'(req_op) : op_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
      op_ff <= op_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_op)
                  OP_LOAD:  state_in = ST_COMMIT;
                  OP_MOVE:  state_in = ST_CHECK;
                  OP_QUERY: state_in = ST_STEP;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_CHECK: begin
            if (!sts.writable)    state_in = ST_IDLE;
            else if (sts.np_zero) state_in = ST_COMMIT;
            else                  state_in = ST_STEP;
         end
         ST_STEP: begin
            state_in = walk_stop ? ST_FINISH : ST_FETCH;
         end
         ST_FETCH: begin
            state_in = sts.parent_zero ? ST_FINISH : ST_STEP;
         end
         ST_FINISH: begin
            if (!is_move) begin
               if (sts.out_free) state_in = ST_IDLE;
            end else begin
               state_in = sts.pos_hit ? ST_IDLE : ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
         end
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.capture  = req_valid;
            cmd.start_np = (req_op == OP_MOVE);
         end
         ST_CHECK: begin
         end
         ST_STEP: begin
            cmd.fetch = !walk_stop;
         end
         ST_FETCH: begin
            cmd.advance = !sts.parent_zero;
         end
         ST_FINISH: begin
            cmd.reply = !is_move && sts.out_free;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== design/dfrq_dpath.sv =====
// datapath: parent memory, walk pointer, step counter, clear sweep and response register
module dfrq_dpath #(
   parameter int unsigned NODE_COUNT = dfrq_pkg::NODE_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  dfrq_pkg::idx_type req_node,
   input  dfrq_pkg::idx_type req_new_parent,
   input  logic              rsp_ready,
   input  dfrq_pkg::cmd_type cmd,
   output dfrq_pkg::sts_type sts,
   output logic              rsp_valid,
   output dfrq_pkg::idx_type rsp_root
);
   import dfrq_pkg::*;

   localparam int unsigned SLOT_COUNT = (NODE_COUNT < SLOT_MAX) ? NODE_COUNT : SLOT_MAX;
   localparam int unsigned ADDR_W     = $clog2(SLOT_COUNT);
   localparam int unsigned CNT_W      = $clog2(SLOT_COUNT + 1);
   localparam logic [IDX_W:0]    SLOT_LIM  = (IDX_W+1)'(SLOT_COUNT);
   localparam logic [CNT_W-1:0]  STEP_LIM  = CNT_W'(SLOT_COUNT);
   localparam logic [ADDR_W-1:0] CLR_LAST  = ADDR_W'(SLOT_COUNT - 1);

   idx_type parent_mem [SLOT_COUNT];

   idx_type           node_ff, node_in;
   idx_type           np_ff, np_in;
   idx_type           pos_ff, pos_in;
   idx_type           rd_data_ff;
   idx_type           root_ff, root_in;
   logic [CNT_W-1:0]  step_ff, step_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   idx_type           mem_wdata;

   assign sts.clear_last   = (clr_ff == CLR_LAST);
   assign sts.writable     = (node_ff != '0) && ({1'b0, node_ff} < SLOT_LIM);
   assign sts.np_zero      = (np_ff == '0);
   assign sts.step_full    = (step_ff == STEP_LIM);
   assign sts.pos_hit      = (pos_ff == node_ff);
   assign sts.pos_in_store = (pos_ff != '0) && ({1'b0, pos_ff} < SLOT_LIM);
   assign sts.parent_zero  = (rd_data_ff == '0);
   assign sts.out_free     = !rsp_valid_ff || rsp_ready;

   assign mem_we    = cmd.clear_step || (cmd.commit && sts.writable);
   assign mem_waddr = cmd.clear_step ? clr_ff : node_ff[ADDR_W-1:0];
   assign mem_wdata = cmd.clear_step ? '0 : np_ff;

   always_comb begin
      node_in      = cmd.capture ? req_node : node_ff;
      np_in        = cmd.capture ? req_new_parent : np_ff;
      pos_in       = pos_ff;
      step_in      = step_ff;
      if (cmd.capture) begin
         pos_in  = cmd.start_np ? req_new_parent : req_node;
         step_in = '0;
      end else if (cmd.advance) begin
         pos_in  = rd_data_ff;
         step_in = step_ff + CNT_W'(1);
      end
      clr_in       = cmd.clear_step ? clr_ff + ADDR_W'(1) : clr_ff;
      root_in      = cmd.reply ? pos_ff : root_ff;
      rsp_valid_in = cmd.reply ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      node_ff <= node_in;
      np_ff   <= np_in;
      pos_ff  <= pos_in;
      step_ff <= step_in;
      root_ff <= root_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) parent_mem[mem_waddr] <= mem_wdata;
      if (cmd.fetch) rd_data_ff <= parent_mem[pos_ff[ADDR_W-1:0]];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_root  = root_ff;

endmodule

// ===== design/dynamic_forest_root_query_unit.sv =====
// top level of the forest root query unit: parent store with load, move and root query
//
//  channel  dir  handshake      payload
//  -------  ---  -------------  ---------------------------------------------
//  req_ch   in   valid / ready  op (2b), node (16b), new_parent (16b)
//  rsp_ch   out  valid / ready  root (16b), one per query request only
//
// one request at a time; a query, and a move with a nonzero new parent, walk the
// parent chain, where each hop walked, and the check at the root, is a memory read
// followed by a decide step
// after reset the parent memory is swept to zero, one entry a cycle, over all
// min(NODE_COUNT, 65536) entries, while req_ch.ready stays low
// the response sits in an output register, so a new request is taken while it waits;
// a query only finishes once that register is free
module dynamic_forest_root_query_unit #(
   parameter int unsigned NODE_COUNT = dfrq_pkg::NODE_COUNT_DEF
) (
   input logic        clock,
   input logic        reset,
   dfrq_req_if.sink   req_ch,
   dfrq_rsp_if.source rsp_ch
);
   import dfrq_pkg::*;

   // command and status bundles between sequencer and datapath
   cmd_type cmd;
   sts_type sts;

   // sequencer: clear sweep, decode, walk control
   dfrq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_op    (req_ch.op),
      .sts       (sts),
      .req_ready (req_ch.ready),
      .cmd       (cmd)
   );

   // datapath: parent memory, walk pointer, hop counter, response register
   dfrq_dpath #(
      .NODE_COUNT (NODE_COUNT)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_node       (req_ch.node),
      .req_new_parent (req_ch.new_parent),
      .rsp_ready      (rsp_ch.ready),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_valid      (rsp_ch.valid),
      .rsp_root       (rsp_ch.root)
   );

endmodule
